/* src/adrd_pkg.sv */
// shared types and constants for the dead-reckoning distance accelerator
package adrd_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_ACCEL_MEAN   = 3'd0;
  localparam logic [2:0] REG_ACCEL_OFFSET = 3'd1;
  localparam logic [2:0] REG_REJECT_LIMIT = 3'd2;
  localparam logic [2:0] REG_FILTER_ALPHA = 3'd3;
  localparam logic [2:0] REG_ACCEL_GAIN   = 3'd4;

  localparam int unsigned CFG_ADDR_W = 5;

  // register reset values
  localparam logic [23:0] MEAN_RST   = 24'd0;
  localparam logic [23:0] OFFSET_RST = 24'd0;
  localparam logic [23:0] LIMIT_RST  = 24'hFFFFFF;
  localparam logic [16:0] ALPHA_RST  = 17'd32768;
  localparam logic [23:0] GAIN_RST   = 24'd10045;

  localparam logic [16:0] ALPHA_ONE  = 17'h10000;

  // millisecond to second conversion
  localparam logic [10:0] MS_PER_S   = 11'd1000;
  localparam logic [11:0] MS_TWO_S   = 12'd2000;
  localparam logic [63:0] MS_HALF    = 64'd500;
  // floor(2^42 / 1000), scaled reciprocal of the millisecond divisor
  localparam logic [32:0] MS_RECIP   = 33'd4398046511;

  localparam logic        OP_SAMPLE  = 1'b0;
  localparam logic        OP_CLEAR   = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [15:0] accel_sample;
    logic [31:0]        time_ms;
  } in_word_t;

  typedef struct packed {
    logic               rejected;
    logic signed [31:0] accel_ms2;
    logic signed [31:0] velocity;
    logic [31:0]        distance;
  } out_word_t;

endpackage

/* src/accel_dead_reckoning_distance_top.sv */
// top level of the dead-reckoning distance accelerator: sequencer and shared multiplier
//
// Each word carries a raw Y-axis accelerometer sample and a millisecond timestamp, or a
// clear command (op = 1). A sample word runs the outlier test, filter and gain scaling
// (S_TEST, S_FILT, S_G0..S_G2), then two passes (velocity, then distance) on the shared
// 34x18 multiplier: magnitude times dt (S_M0..S_M2), a multiply by a scaled reciprocal
// of 1000 (S_Q0..S_Q2), a correction step of the quotient (S_FIX) and an update (S_UPD);
// last, S_DONE loads the output register. A rejected sample goes from S_TEST to S_DONE
// and a clear word from S_IDLE to S_DONE. in_ready is high only while the sequencer is
// idle, so one word is in flight at a time; a finished result waits in the output
// register while the next word is accepted. Registers sit on an APB-style port at byte
// address 4*index; write them only while the block is idle, which it does not enforce.
module accel_dead_reckoning_distance_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  adrd_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output adrd_pkg::out_word_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [adrd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import adrd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_FILT,
    S_G0,
    S_G1,
    S_G2,
    S_M0,
    S_M1,
    S_M2,
    S_Q0,
    S_Q1,
    S_Q2,
    S_FIX,
    S_UPD,
    S_DONE
  } state_t;

  // configuration registers
  logic [23:0] mean_r, offset_r, limit_r, gain_r;
  logic [16:0] alpha_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  state_t      state_r, state_nxt;
  logic [15:0] smp_r, smp_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [31:0] vel_r, vel_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic [31:0] last_r, last_nxt;
  logic [51:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [33:0] diff_r, diff_nxt;
  logic [31:0] accel_r, accel_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic        big_r, big_nxt;
  logic        phase_r, phase_nxt;
  out_word_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;

  // datapath helpers
  logic [16:0] alpha_c;
  logic [16:0] sdiff, sd_mag;
  logic [25:0] dm, dm_mag;
  logic        reject_w;
  logic [33:0] filt_f, off_s;
  logic [63:0] gsum;
  logic [31:0] accel_w;
  logic [63:0] xsum;
  logic [63:0] qsum;
  logic [11:0] p12, rfix;
  logic [1:0]  qstep;
  logic [33:0] vsum, dv;
  logic [31:0] vnew;
  logic [32:0] dsum;
  logic [31:0] dnew;

  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= MEAN_RST;
      offset_r <= OFFSET_RST;
      limit_r  <= LIMIT_RST;
      alpha_r  <= ALPHA_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ACCEL_MEAN:   mean_r   <= pwdata[23:0];
        REG_ACCEL_OFFSET: offset_r <= pwdata[23:0];
        REG_REJECT_LIMIT: limit_r  <= pwdata[23:0];
        REG_FILTER_ALPHA: alpha_r  <= pwdata[16:0];
        REG_ACCEL_GAIN:   gain_r   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ACCEL_MEAN:   prdata = {8'd0, mean_r};
      REG_ACCEL_OFFSET: prdata = {8'd0, offset_r};
      REG_REJECT_LIMIT: prdata = {8'd0, limit_r};
      REG_FILTER_ALPHA: prdata = {15'd0, alpha_r};
      REG_ACCEL_GAIN:   prdata = {8'd0, gain_r};
      default:          prdata = 32'd0;
    endcase
  end

  // outlier test
  assign sdiff    = {smp_r[15], smp_r} - {prev_r[15], prev_r};
  assign sd_mag   = sdiff[16] ? (~sdiff + 17'd1) : sdiff;
  assign dm       = {{2{smp_r[15]}}, smp_r, 8'd0} - {{2{mean_r[23]}}, mean_r};
  assign dm_mag   = dm[25] ? (~dm + 26'd1) : dm;
  assign reject_w = (dm_mag > {2'd0, limit_r}) && ({sd_mag, 8'd0} > {1'b0, limit_r});

  assign alpha_c  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_TEST: begin
        mul_a = {{17{sdiff[16]}}, sdiff};
        mul_b = {1'b0, alpha_c};
      end
      S_G0: begin
        mul_a = diff_r;
        mul_b = {6'd0, gain_r[11:0]};
      end
      S_G1: begin
        mul_a = diff_r;
        mul_b = {6'd0, gain_r[23:12]};
      end
      S_M0: begin
        mul_a = {2'd0, mag_r};
        mul_b = {2'd0, dt_r[15:0]};
      end
      S_M1: begin
        mul_a = {2'd0, mag_r};
        mul_b = {2'd0, dt_r[31:16]};
      end
      S_Q0: begin
        mul_a = {1'b0, MS_RECIP};
        mul_b = {2'd0, acc_r[25:10]};
      end
      S_Q1: begin
        mul_a = {1'b0, MS_RECIP};
        mul_b = {2'd0, acc_r[41:26]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // filter and offset: f = p*2^16 + a*(s-p)
  assign filt_f = {{2{prev_r[15]}}, prev_r, 16'd0} + prod_r[33:0];
  assign off_s  = {{2{offset_r[23]}}, offset_r, 8'd0};

  // gain scaling, round half up, saturate to 32 bits
  assign gsum    = acc_r + {prod_r, 12'd0} + (64'd1 << 23);
  assign accel_w = (gsum[63:55] == {9{gsum[63]}}) ? gsum[55:24] :
                   (gsum[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // product of magnitude and dt, plus half of the divisor
  assign xsum = acc_r + {prod_r[47:0], 16'd0} + MS_HALF;

  // quotient estimate (x/1024) * recip / 2^32 falls at most two short
  assign qsum  = acc_r + {prod_r[47:0], 16'd0};
  // low 12 bits of 1000 * estimate, and the remainder left over
  assign p12   = {quo_r[1:0], 10'd0} - {quo_r[7:0], 4'd0} - {quo_r[8:0], 3'd0};
  assign rfix  = rem_r - p12;
  assign qstep = (rfix >= MS_TWO_S) ? 2'd2 :
                 ((rfix >= {1'b0, MS_PER_S}) ? 2'd1 : 2'd0);

  // velocity and distance updates
  assign dv   = accel_r[31] ? (~{2'd0, quo_r} + 34'd1) : {2'd0, quo_r};
  assign vsum = {{2{vel_r[31]}}, vel_r} + dv;
  always_comb begin
    if (big_r) begin
      vnew = accel_r[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (vsum[33:31] == {3{vsum[33]}}) begin
      vnew = vsum[31:0];
    end else begin
      vnew = vsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end
  assign dsum = {1'b0, dist_r} + {1'b0, quo_r};
  assign dnew = (big_r || dsum[32]) ? 32'hFFFF_FFFF : dsum[31:0];

  always_comb begin
    state_nxt     = state_r;
    smp_nxt       = smp_r;
    now_nxt       = now_r;
    dt_nxt        = dt_r;
    prev_nxt      = prev_r;
    vel_nxt       = vel_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    prod_nxt      = mul_p;
    acc_nxt       = acc_r;
    diff_nxt      = diff_r;
    accel_nxt     = accel_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    big_nxt       = big_r;
    phase_nxt     = phase_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_nxt   = in_data.accel_sample;
          now_nxt   = in_data.time_ms;
          phase_nxt = 1'b0;
          if (in_data.op == OP_CLEAR) begin
            vel_nxt   = '0;
            dist_nxt  = '0;
            last_nxt  = in_data.time_ms;
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        dt_nxt = now_r - last_r;
        if (reject_w) begin
          res_nxt.rejected  = 1'b1;
          res_nxt.accel_ms2 = '0;
          res_nxt.velocity  = vel_r;
          res_nxt.distance  = dist_r;
          state_nxt         = S_DONE;
        end else begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        diff_nxt  = filt_f - off_s;
        state_nxt = S_G0;
      end
      S_G0: begin
        state_nxt = S_G1;
      end
      S_G1: begin
        acc_nxt   = {{12{prod_r[51]}}, prod_r};
        state_nxt = S_G2;
      end
      S_G2: begin
        accel_nxt = accel_w;
        mag_nxt   = accel_w[31] ? (~accel_w + 32'd1) : accel_w;
        state_nxt = S_M0;
      end
      S_M0: begin
        state_nxt = S_M1;
      end
      S_M1: begin
        acc_nxt   = {12'd0, prod_r};
        state_nxt = S_M2;
      end
      S_M2: begin
        // quotient of 2^32 or more saturates either accumulator
        big_nxt   = xsum[63:32] >= {21'd0, MS_PER_S};
        acc_nxt   = xsum;
        rem_nxt   = xsum[11:0];
        state_nxt = S_Q0;
      end
      S_Q0: begin
        state_nxt = S_Q1;
      end
      S_Q1: begin
        acc_nxt   = {15'd0, prod_r[48:0]};
        state_nxt = S_Q2;
      end
      S_Q2: begin
        quo_nxt   = qsum[63:32];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        quo_nxt   = quo_r + {30'd0, qstep};
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!phase_r) begin
          vel_nxt   = vnew;
          mag_nxt   = vnew[31] ? (~vnew + 32'd1) : vnew;
          phase_nxt = 1'b1;
          state_nxt = S_M0;
        end else begin
          dist_nxt          = dnew;
          prev_nxt          = smp_r;
          last_nxt          = now_r;
          res_nxt.rejected  = 1'b0;
          res_nxt.accel_ms2 = accel_r;
          res_nxt.velocity  = vel_r;
          res_nxt.distance  = dnew;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      vel_r       <= '0;
      dist_r      <= '0;
      last_r      <= '0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      vel_r       <= vel_nxt;
      dist_r      <= dist_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
    end
    smp_r      <= smp_nxt;
    now_r      <= now_nxt;
    dt_r       <= dt_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    diff_r     <= diff_nxt;
    accel_r    <= accel_nxt;
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    big_r      <= big_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // remainder after the reciprocal estimate is below three divisors
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && !big_r) |-> (rfix < 12'd3000))
    else $error("quotient estimate out of range");

  // a discarded sample leaves the integrator state untouched
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST && reject_w) |=>
      ($stable(vel_r) && $stable(dist_r) && $stable(last_r) && $stable(prev_r)))
    else $error("rejected sample changed state");

  // distance never decreases on a sample update
  a_dist_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && phase_r) |=> (dist_r >= $past(dist_r)))
    else $error("distance decreased");
`endif

endmodule

/* sim/tb.sv */
// self-checking testbench for the dead-reckoning distance accelerator
module tb;
  import adrd_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 60;
  localparam int MAX_REPORTS  = 10;

  // register slots past the last one; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  accel_dead_reckoning_distance_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // odometer model: configuration and state
  logic signed [23:0] mean_q   = MEAN_RST;
  logic signed [23:0] offset_q = OFFSET_RST;
  logic [23:0]        limit_q  = LIMIT_RST;
  logic [16:0]        alpha_q  = ALPHA_RST;
  logic [23:0]        gain_q   = GAIN_RST;

  logic signed [15:0] prev_raw = '0;
  logic signed [31:0] vel_acc  = '0;
  logic [31:0]        dist_acc = '0;
  logic [31:0]        last_ms  = '0;

  in_word_t  sample_queue[$];
  out_word_t predicted_words[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int words_sent     = 0;
  int clears_sent    = 0;
  int results_seen   = 0;
  int rejects_seen   = 0;
  int quiet_cycles   = 0;
  logic [31:0] stamp_ms = '0;

  function automatic logic signed [31:0] sat_s32(longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic out_word_t dead_reckon_step(in_word_t w);
    out_word_t r;
    longint s, p, mean_l, lim, dev_mean, dev_prev, a, one_q16, filt, diff, gain_l, acc;
    longint acc_l, dv, vel_l;
    longint unsigned mag_u, dt, prod, q, dd, dsum;
    logic [31:0] elapsed;
    logic signed [31:0] accel;
    r = '0;
    if (w.op == OP_CLEAR) begin
      vel_acc = '0;
      dist_acc = '0;
      last_ms = w.time_ms;
      return r;
    end
    s = $signed(w.accel_sample);
    p = $signed(prev_raw);
    mean_l = $signed(mean_q);
    lim = limit_q;
    dev_mean = s * 256 - mean_l;
    dev_prev = s * 256 - p * 256;
    if (dev_mean < 0) dev_mean = -dev_mean;
    if (dev_prev < 0) dev_prev = -dev_prev;
    // outlier only when far from both the mean and the last kept sample
    if (dev_mean > lim && dev_prev > lim) begin
      r.rejected = 1'b1;
      r.velocity = vel_acc;
      r.distance = dist_acc;
      return r;
    end
    one_q16 = ALPHA_ONE;
    a = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    filt = a * s + (one_q16 - a) * p;
    diff = filt - longint'($signed(offset_q)) * 256;
    gain_l = gain_q;
    acc = (diff * gain_l + 8388608) >>> 24;
    accel = sat_s32(acc);

    elapsed = w.time_ms - last_ms;
    dt = elapsed;

    acc_l = accel;
    mag_u = (acc_l < 0) ? -acc_l : acc_l;
    prod = mag_u * dt;
    q = (prod + 500) / 1000;
    dv = (acc_l < 0) ? -longint'(q) : longint'(q);
    vel_l = vel_acc;
    vel_acc = sat_s32(vel_l + dv);

    vel_l = vel_acc;
    mag_u = (vel_l < 0) ? -vel_l : vel_l;
    prod = mag_u * dt;
    dd = (prod + 500) / 1000;
    dsum = longint'(dist_acc) + dd;
    dist_acc = (dsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dsum[31:0];

    prev_raw = w.accel_sample;
    last_ms = w.time_ms;
    r.accel_ms2 = accel;
    r.velocity = vel_acc;
    r.distance = dist_acc;
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predicted_words.push_back(dead_reckon_step(in_data));
        words_sent++;
        if (in_data.op == OP_CLEAR) clears_sent++;
      end
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= sample_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result word with nothing outstanding: %h", out_data);
        end else begin
          want = predicted_words.pop_front();
          if (out_data.rejected) rejects_seen++;
          if (out_data.rejected !== want.rejected)
            note_mismatch("rejected", 32'(want.rejected), 32'(out_data.rejected));
          if (out_data.accel_ms2 !== want.accel_ms2)
            note_mismatch("accel_ms2", want.accel_ms2, out_data.accel_ms2);
          if (out_data.velocity !== want.velocity)
            note_mismatch("velocity", want.velocity, out_data.velocity);
          if (out_data.distance !== want.distance)
            note_mismatch("distance", want.distance, out_data.distance);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding",
               STALL_LIMIT, predicted_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ACCEL_MEAN:   mean_q   = value[23:0];
      REG_ACCEL_OFFSET: offset_q = value[23:0];
      REG_REJECT_LIMIT: limit_q  = value[23:0];
      REG_FILTER_ALPHA: alpha_q  = value[16:0];
      REG_ACCEL_GAIN:   gain_q   = value[23:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] mean, input logic [31:0] offset,
                              input logic [31:0] limit, input logic [31:0] alpha,
                              input logic [31:0] gain);
    reg_write(REG_ACCEL_MEAN, mean);
    reg_write(REG_ACCEL_OFFSET, offset);
    reg_write(REG_REJECT_LIMIT, limit);
    reg_write(REG_FILTER_ALPHA, alpha);
    reg_write(REG_ACCEL_GAIN, gain);
  endtask

  task automatic wait_quiet();
    while (sample_queue.size() != 0 || in_valid || predicted_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_word(input logic op, input int value, input logic [31:0] dt);
    in_word_t w;
    stamp_ms = stamp_ms + dt;
    w.op = op;
    w.accel_sample = value[15:0];
    w.time_ms = stamp_ms;
    sample_queue.push_back(w);
  endtask

  task automatic add_random_items(input int count);
    int roll, v, walk, center;
    logic [31:0] dt;
    walk = $signed(prev_raw);
    center = $signed(mean_q);
    center = center >>> 8;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if ($urandom_range(19) == 0) dt = $urandom();
      else dt = $urandom_range(0, 200);
      if (roll < 50) begin
        v = walk + $urandom_range(0, 128) - 64;
      end else if (roll < 65) begin
        v = center + $urandom_range(0, 256) - 128;
      end else if (roll < 75) begin
        v = $urandom_range(1) ? 32767 : -32768;
      end else begin
        v = $signed($urandom_range(0, 65535) - 32768);
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (roll >= 92) begin
        push_word(OP_CLEAR, $urandom_range(0, 65535), dt);
      end else begin
        push_word(OP_SAMPLE, v, dt);
        walk = v;
      end
    end
  endtask

  initial begin
    logic [31:0] gain;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: first sample from time zero, full-scale samples, clear,
    // huge gaps and a timestamp wrap driving velocity and distance into saturation
    push_word(OP_SAMPLE, 0, 32'd0);
    push_word(OP_SAMPLE, 32767, 32'd10);
    push_word(OP_SAMPLE, -32768, 32'd10);
    push_word(OP_CLEAR, -32768, 32'd5);
    push_word(OP_SAMPLE, 1000, 32'hFFFF_FFC0);
    push_word(OP_SAMPLE, 1000, 32'd80);
    push_word(OP_SAMPLE, 32767, 32'h7FFF_FFFF);
    push_word(OP_SAMPLE, 32767, 32'hFFFF_FFFF);
    push_word(OP_SAMPLE, 32767, 32'hFFFF_FFFF);
    push_word(OP_SAMPLE, -32768, 32'hFFFF_FFFF);
    push_word(OP_SAMPLE, -32768, 32'hFFFF_FFFF);
    push_word(OP_SAMPLE, -32768, 32'hFFFF_FFFF);
    push_word(OP_CLEAR, 32767, 32'd3);
    wait_quiet();

    // tight outlier window, alpha above one, maximum gain
    program_regs(32'd0, 32'd1280, 32'd25600, 32'd70000, 32'hFF_FFFF);
    @(negedge clk);
    push_word(OP_SAMPLE, 10, 32'd10);
    push_word(OP_SAMPLE, 20000, 32'd10);
    push_word(OP_SAMPLE, 100, 32'd10);
    push_word(OP_SAMPLE, 30000, 32'd10);
    push_word(OP_SAMPLE, 200, 32'd10);
    push_word(OP_SAMPLE, -32768, 32'd10);
    push_word(OP_SAMPLE, 32767, 32'd10);
    push_word(OP_CLEAR, 0, 32'd1);
    push_word(OP_SAMPLE, 0, 32'd0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_quiet();
      if (seg == 0) begin
        program_regs(32'h80_0000, 32'h7F_FFFF, 32'hFF_FFFF, 32'd0, 32'hFF_FFFF);
      end else if (seg == 1) begin
        program_regs(32'h7F_FFFF, 32'h80_0000, 32'd0, 32'd65536, 32'd1);
        reg_write(REG_UNMAPPED_LO, $urandom());
        reg_write(REG_UNMAPPED_HI, $urandom());
      end else if (seg == 2) begin
        program_regs($urandom(), $urandom(), $urandom_range(0, 65535), 32'h1_FFFF, 32'd0);
      end else begin
        gain = $urandom_range(1) ? $urandom() : $urandom_range(0, 65535);
        program_regs($urandom(), $urandom(),
                     $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 65535),
                     $urandom_range(0, 131071), gain);
      end
      @(negedge clk);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      add_random_items(SEG_ITEMS);
    end
    wait_quiet();

    $display("%0d words sent (%0d clears) over %0d register settings and four idle patterns",
             words_sent, clears_sent, SEGMENTS + 2);
    $display("%0d results checked, %0d of them rejected samples, %0d mismatches",
             results_seen, rejects_seen, mismatches);
    if (mismatches == 0 && predicted_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
